/* hdl/pixel_block_downscale_5x4_to_4x3_macros.svh */
// ----------------------------------------------------------------------------
// pixel_block_downscale_5x4_to_4x3 assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as disable
// ----------------------------------------------------------------------------
`ifndef PIXEL_BLOCK_DOWNSCALE_5X4_TO_4X3_MACROS_SVH
`define PIXEL_BLOCK_DOWNSCALE_5X4_TO_4X3_MACROS_SVH

// same-cycle implication
`define PBDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pbds_pkg.sv */
// ----------------------------------------------------------------------------
// pbds_pkg
// shared constants, types and the rgb565 halving function of the downscaler
// ----------------------------------------------------------------------------
`default_nettype none

package pbds_pkg;

  localparam int MAX_BLOCKS_ACROSS = 64;
  localparam int BLOCK_W           = 5;
  localparam int LANES             = 3;
  localparam int RESULTS           = 12;
  localparam int STORE_DEPTH       = BLOCK_W * MAX_BLOCKS_ACROSS;
  localparam int STORE_AW          = $clog2(STORE_DEPTH);
  // wide enough for MAX_BLOCKS_ACROSS up to 256
  localparam int ACROSS_W          = 9;
  // (x * 205) >> 10 equals x / 5 for every x below 1024
  localparam int RECIP5            = 205;

  localparam logic [15:0] HALF_MASK = 16'hF7DE;

  localparam logic [1:0] ROW_BOTTOM = 2'd3;
  localparam logic [2:0] POS_LAST   = 3'd4;

  localparam logic [2:0] CFG_LINE_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_WINDOW_LEFT   = 3'd1;
  localparam logic [2:0] CFG_WINDOW_TOP    = 3'd2;
  localparam logic [2:0] CFG_BLOCKS_ACROSS = 3'd3;
  localparam logic [2:0] CFG_BLOCKS_DOWN   = 3'd4;

  localparam logic [9:0] LINE_WIDTH_RST    = 10'd320;
  localparam logic [9:0] WINDOW_LEFT_RST   = 10'd10;
  localparam logic [9:0] WINDOW_TOP_RST    = 10'd10;
  localparam logic [6:0] BLOCKS_ACROSS_RST = 7'd60;
  localparam logic [7:0] BLOCKS_DOWN_RST   = 8'd53;

  typedef logic [15:0] pix_t;
  // one line store word: lane 0 is the band's top row
  typedef pix_t [LANES-1:0] colw_t;

  typedef struct packed {
    colw_t [BLOCK_W-1:0] cols;
    pix_t  [BLOCK_W-1:0] d;
    logic  [7:0]         x0;
    logic  [9:0]         y0;
  } block_t;

  typedef struct packed {
    logic   valid;
    block_t blk;
  } hand_t;

  typedef struct packed {
    logic [9:0] line_width;
    logic [9:0] window_left;
    logic [9:0] window_top;
    logic [6:0] blocks_across;
    logic [7:0] blocks_down;
  } cfg_t;

  function automatic pix_t half(input pix_t v);
    return (v & HALF_MASK) >> 1;
  endfunction

endpackage

`default_nettype wire

/* hdl/pixel_block_downscale_5x4_to_4x3.sv */
// ----------------------------------------------------------------------------
// pixel_block_downscale_5x4_to_4x3
// rgb565 blend downscaler, 5x4 source blocks to 4x3 output pixels
// ----------------------------------------------------------------------------
// Source pixels enter in raster order and are halved per channel on entry.
// The first three rows of each band go into a 320 x 48-bit line store that
// keeps the three rows of one column in one word (read-modify-write, with
// forwarding between the write and the next read); the bottom row reads its
// columns back one per pixel. Pixels are taken one per clock, except that
// the input stalls while a finished block waits for the blend unit: until
// the idle blend unit takes it, or until the previous block's last result
// is issued when it is still emitting. The blend unit emits a block's
// twelve results at one per clock while out_stall is low. The fifth pixel
// of a block's bottom row passes the stage 1 and stage 2 registers, the
// pending block and the blend unit's active block before the block's first
// result is registered at the output. Configuration writes are always ready
// and should be made while the block is idle.
`default_nettype none

`include "pixel_block_downscale_5x4_to_4x3_macros.svh"

module pixel_block_downscale_5x4_to_4x3 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pixel,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_pixel,
  output logic [7:0]       out_x,
  output logic [9:0]       out_y,
  output logic             out_last_of_run,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  import pbds_pkg::*;

  cfg_t  cfg_r;
  hand_t hand;
  logic  take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width    <= LINE_WIDTH_RST;
      cfg_r.window_left   <= WINDOW_LEFT_RST;
      cfg_r.window_top    <= WINDOW_TOP_RST;
      cfg_r.blocks_across <= BLOCKS_ACROSS_RST;
      cfg_r.blocks_down   <= BLOCKS_DOWN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINE_WIDTH:    cfg_r.line_width    <= cfg_data;
        CFG_WINDOW_LEFT:   cfg_r.window_left   <= cfg_data;
        CFG_WINDOW_TOP:    cfg_r.window_top    <= cfg_data;
        CFG_BLOCKS_ACROSS: cfg_r.blocks_across <= cfg_data[6:0];
        CFG_BLOCKS_DOWN:   cfg_r.blocks_down   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  pbds_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .hand           (hand),
    .take           (take)
  );

  pbds_blend u_blend (
    .clk             (clk),
    .rst_n           (rst_n),
    .hand            (hand),
    .take            (take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel       (out_pixel),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_last_of_run (out_last_of_run)
  );

  `PBDS_ASSERT_NOW(a_take_needs_block, take, hand.valid, "block taken with none queued")
  `PBDS_ASSERT_NEXT(a_block_kept, hand.valid && !take, hand.valid, "queued block lost")
  `PBDS_ASSERT_NEXT(a_last_spacing, out_valid && out_last_of_run && !out_stall,
                    !(out_valid && out_last_of_run), "end of block marked twice in a row")

endmodule

`default_nettype wire

/* hdl/pbds_ram.sv */
// ----------------------------------------------------------------------------
// pbds_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pbds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/pbds_front.sv */
// ----------------------------------------------------------------------------
// pbds_front
// raster counters, window decode and line store read-modify-write pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module pbds_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pbds_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [15:0]     in_pixel,
  input  wire logic            in_frame_start,
  output pbds_pkg::hand_t      hand,
  input  wire logic            take
);

  import pbds_pkg::*;

  logic          accept;
  logic [9:0]    col_r, row_r, col_cur, row_cur;
  logic          wrap;
  logic          in_win;

  logic          s1_valid_r;
  logic [9:0]    s1_rel_row_r, s1_rel_col_r;
  pix_t          s1_h_r;

  logic [17:0]   prod;
  logic [7:0]    block;
  logic [9:0]    block5;
  logic [7:0]    band;
  logic [2:0]    pos;
  logic [ACROSS_W-1:0] across;
  logic          fits;
  logic          s1_ok;
  logic [STORE_AW-1:0] rd_addr;

  logic          s2_valid_r;
  logic [1:0]    s2_k_r;
  logic [2:0]    s2_pos_r;
  pix_t          s2_h_r;
  logic [STORE_AW-1:0] s2_addr_r;
  logic [7:0]    s2_x0_r;
  logic [9:0]    s2_y0_r;

  colw_t         ram_rdata, rdata_eff, wr_word;
  logic          wr_en;
  logic          fwd_r;
  colw_t         fwd_data_r;

  colw_t [BLOCK_W-2:0] cols_r;
  pix_t  [BLOCK_W-2:0] d_r;
  block_t        pend_r;
  logic          pend_valid_r;
  logic          pend_load;

  // stage 0: counters and window origin
  assign in_stall = pend_valid_r;
  assign accept   = in_valid & ~in_stall;
  assign col_cur  = in_frame_start ? '0 : col_r;
  assign row_cur  = in_frame_start ? '0 : row_r;
  assign wrap     = ({1'b0, col_cur} + 11'd1) >= {1'b0, cfg.line_width};
  assign in_win   = (row_cur >= cfg.window_top) && (col_cur >= cfg.window_left);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept & in_win;
      if (accept) begin
        if (wrap) begin
          col_r <= '0;
          row_r <= row_cur + 10'd1;
        end else begin
          col_r <= col_cur + 10'd1;
          row_r <= row_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_rel_row_r <= row_cur - cfg.window_top;
    s1_rel_col_r <= col_cur - cfg.window_left;
    s1_h_r       <= half(in_pixel);
  end

  // stage 1: block decode and line store read
  assign prod    = 18'(s1_rel_col_r) * 18'(RECIP5);
  assign block   = prod[17:10];
  assign block5  = 10'({block, 2'b00}) + 10'(block);
  assign pos     = 3'(s1_rel_col_r - block5);
  assign band    = s1_rel_row_r[9:2];
  assign across  = ({2'b00, cfg.blocks_across} > ACROSS_W'(MAX_BLOCKS_ACROSS)) ?
                   ACROSS_W'(MAX_BLOCKS_ACROSS) : ACROSS_W'(cfg.blocks_across);
  assign fits    = (12'(cfg.window_left) + 12'(block5) + 12'd4) < 12'(cfg.line_width);
  assign s1_ok   = s1_valid_r && (band < cfg.blocks_down) &&
                   (ACROSS_W'(block) < across) && fits;
  assign rd_addr = STORE_AW'(s1_rel_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_ok;
    end
  end

  always_ff @(posedge clk) begin
    s2_k_r    <= s1_rel_row_r[1:0];
    s2_pos_r  <= pos;
    s2_h_r    <= s1_h_r;
    s2_addr_r <= rd_addr;
    s2_x0_r   <= 8'({block, 2'b00});
    s2_y0_r   <= 10'({band, 1'b0}) + 10'(band);
  end

  // stage 2: merge into the column word or collect the bottom row
  assign rdata_eff = fwd_r ? fwd_data_r : ram_rdata;
  assign wr_en     = s2_valid_r && (s2_k_r != ROW_BOTTOM);
  assign pend_load = s2_valid_r && (s2_k_r == ROW_BOTTOM) && (s2_pos_r == POS_LAST);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      wr_word[l] = (2'(l) == s2_k_r) ? s2_h_r : rdata_eff[l];
    end
  end

  pbds_ram #(
    .WIDTH ($bits(colw_t)),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_addr_r),
    .wdata (wr_word),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // write and read of the same column in one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= wr_en && (s2_addr_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (pend_load) begin
      pend_valid_r <= 1'b1;
    end else if (take) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && (s2_k_r == ROW_BOTTOM) && (s2_pos_r != POS_LAST)) begin
      cols_r[s2_pos_r[1:0]] <= rdata_eff;
      d_r[s2_pos_r[1:0]]    <= s2_h_r;
    end
    if (pend_load) begin
      pend_r.cols <= {rdata_eff, cols_r};
      pend_r.d    <= {s2_h_r, d_r};
      pend_r.x0   <= s2_x0_r;
      pend_r.y0   <= s2_y0_r;
    end
  end

  assign hand.valid = pend_valid_r;
  assign hand.blk   = pend_r;

endmodule

`default_nettype wire

/* hdl/pbds_blend.sv */
// ----------------------------------------------------------------------------
// pbds_blend
// blends one buffered 5x4 block into twelve results, one per clock while the output is not stalled
// ----------------------------------------------------------------------------
`default_nettype none

module pbds_blend (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pbds_pkg::hand_t hand,
  output logic                 take,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [15:0]          out_pixel,
  output logic [7:0]           out_x,
  output logic [9:0]           out_y,
  output logic                 out_last_of_run
);

  import pbds_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t     state_r;
  logic [3:0] idx_r;
  block_t     act_r;
  logic       adv;
  logic       last_idx;
  pix_t       res;
  logic       out_valid_r;
  pix_t       out_pixel_r;
  logic [7:0] out_x_r;
  logic [9:0] out_y_r;
  logic       out_last_r;

  pix_t a1, a2, a3, a4, a5, b1, b2, b3, b4, b5, c1, c2, c3, c4, c5;
  pix_t d1, d2, d3, d4, d5;

  assign adv      = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign last_idx = idx_r == 4'(RESULTS - 1);
  assign take     = hand.valid && ((state_r == ST_IDLE) || (adv && last_idx));

  assign a1 = act_r.cols[0][0];
  assign a2 = act_r.cols[1][0];
  assign a3 = act_r.cols[2][0];
  assign a4 = act_r.cols[3][0];
  assign a5 = act_r.cols[4][0];
  assign b1 = act_r.cols[0][1];
  assign b2 = act_r.cols[1][1];
  assign b3 = act_r.cols[2][1];
  assign b4 = act_r.cols[3][1];
  assign b5 = act_r.cols[4][1];
  assign c1 = act_r.cols[0][2];
  assign c2 = act_r.cols[1][2];
  assign c3 = act_r.cols[2][2];
  assign c4 = act_r.cols[3][2];
  assign c5 = act_r.cols[4][2];
  assign d1 = act_r.d[0];
  assign d2 = act_r.d[1];
  assign d3 = act_r.d[2];
  assign d4 = act_r.d[3];
  assign d5 = act_r.d[4];

  always_comb begin
    case (idx_r)
      4'd0:    res = a1 + half(b1 + half(a2 + half(a1 + b2)));
      4'd1:    res = a2 + half(a3 + half(b2 + b3));
      4'd2:    res = a4 + half(a3 + half(b3 + b4));
      4'd3:    res = a5 + half(b5 + half(a4 + half(a5 + b4)));
      4'd4:    res = half(b1 + half(b1 + b2)) + half(c1 + half(c1 + c2));
      4'd5:    res = half(b2 + c2) +
                     half(half(b3 + half(b2 + b3)) + half(c3 + half(c2 + c3)));
      4'd6:    res = half(b4 + c4) +
                     half(half(b3 + half(b3 + b4)) + half(c3 + half(c3 + c4)));
      4'd7:    res = half(b5 + half(b4 + b5)) + half(c5 + half(c4 + c5));
      4'd8:    res = d1 + half(c1 + half(d2 + half(c2 + d1)));
      4'd9:    res = d2 + half(d3 + half(c2 + c3));
      4'd10:   res = d4 + half(d3 + half(c3 + c4));
      4'd11:   res = d5 + half(c5 + half(d4 + half(c4 + d5)));
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (take) begin
            state_r <= ST_EMIT;
            idx_r   <= '0;
          end
        end
        ST_EMIT: begin
          if (take) begin
            idx_r <= '0;
          end else if (adv && last_idx) begin
            state_r <= ST_IDLE;
          end else if (adv) begin
            idx_r <= idx_r + 4'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take) begin
      act_r <= hand.blk;
    end
    if (adv) begin
      out_pixel_r <= res;
      out_x_r     <= act_r.x0 + 8'(idx_r[1:0]);
      out_y_r     <= act_r.y0 + 10'(idx_r[3:2]);
      out_last_r  <= last_idx;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel       = out_pixel_r;
  assign out_x           = out_x_r;
  assign out_y           = out_y_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire
